// ----- src/bfth_pkg.sv -----
`timescale 1ns / 1ps
// bfth_pkg: shared constants, controller state type and hash helper for the bloom filter
// no dependencies

package bfth_pkg;

    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_RD1,
        ST_WR1,
        ST_RD2,
        ST_WR2,
        ST_CHK
    } state_t;

    // shift/add mix, all adds wrap at 32 bits
    function automatic logic [31:0] jenkins_mix(input logic [31:0] key);
        logic [31:0] x;
        x = key;
        x = x + (x << 10);
        x = x ^ (x >> 6);
        x = x + (x << 3);
        x = x ^ (x >> 11);
        x = x + (x << 15);
        return x;
    endfunction

endpackage

// ----- src/bfth_hash.sv -----
`timescale 1ns / 1ps
// bfth_hash: multi-cycle hash unit, murmur-style mix over three registered multiplies for h1, shift/add mix for h2
// depends on bfth_pkg

module bfth_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] key,
    output logic        done,
    output logic [31:0] h1,
    output logic [31:0] h2
);

    logic        busy_reg;
    logic [1:0]  step_reg;
    logic        done_reg;
    logic [31:0] k_reg;
    logic [31:0] j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            k_reg <= key * bfth_pkg::MIX_MUL;
            j_reg <= bfth_pkg::jenkins_mix(key);
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:    k_reg <= (k_reg ^ (k_reg >> 24)) * bfth_pkg::MIX_MUL;
                2'd1:    k_reg <= (k_reg ^ (k_reg >> 13)) * bfth_pkg::MIX_MUL;
                default: k_reg <= k_reg ^ (k_reg >> 15);
            endcase
        end
    end

    assign done = done_reg;
    assign h1   = k_reg;
    assign h2   = j_reg;

endmodule

// ----- src/bfth_mod.sv -----
`timescale 1ns / 1ps
// bfth_mod: restoring remainder unit, one dividend bit per cycle
// no dependencies

module bfth_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [16:0] rem
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] dvd_reg;
    logic [16:0] rem_reg;
    logic [17:0] trial;

    assign trial = {rem_reg, dvd_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= 17'd0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_reg <= 17'(trial - {1'b0, divisor});
            else
                rem_reg <= trial[16:0];
        end
    end

    assign done = done_reg;
    // remainder is below the divisor, so it fits the 17-bit divisor width
    assign rem  = rem_reg;

endmodule

// ----- src/bfth_store.sv -----
`timescale 1ns / 1ps
// bfth_store: single-port word store, registered read data
// no dependencies

module bfth_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bloom_filter_two_hash.sv -----
`timescale 1ns / 1ps
// bloom filter, two hashes over a word store; one item at a time
// an add runs accept, hash and the bit-serial remainder, then reads and writes each of its two words;
// a query reads both words, and its result is registered once the output is free
// the input stalls until the item is done, a query also waiting for a free output;
// a query result leaves through an output register
// reset: active_bits returns to 65536 and a clearing pass writes zero to every
// word, during which no transfer is taken

module bloom_filter_two_hash #(
    parameter int FILTER_BITS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] key,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        maybe_present,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    localparam int WORD_COUNT = (FILTER_BITS + 31) / 32;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [31:0] FB32      = 32'(FILTER_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);

    bfth_pkg::state_t state_reg, state_next;

    logic [16:0]   active_bits_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          op_reg;
    logic [31:0]   key_reg;
    logic [16:0]   pos1_reg;
    logic [16:0]   pos2_reg;
    logic          bit1_reg;
    logic          out_valid_reg;
    logic          maybe_reg;
    logic          hash_go_reg;

    // effective modulus: zero counts as one, clamp to FILTER_BITS
    logic [31:0] act32;
    logic [16:0] eff_n;

    always_comb
    begin
        act32 = {15'd0, active_bits_reg};
        if (act32 == 32'd0)
            act32 = 32'd1;
        if (act32 > FB32)
            act32 = FB32;
        eff_n = act32[16:0];
    end

    // hash and remainder units
    logic        hash_start;
    logic        hash_done;
    logic [31:0] h1, h2;
    logic        mod_start;
    logic        mod1_done, mod2_done;
    logic [16:0] rem1, rem2;

    bfth_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_reg),
        .done  (hash_done),
        .h1    (h1),
        .h2    (h2)
    );

    bfth_mod u_mod1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (h1),
        .divisor  (eff_n),
        .done     (mod1_done),
        .rem      (rem1)
    );

    bfth_mod u_mod2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (h2),
        .divisor  (eff_n),
        .done     (mod2_done),
        .rem      (rem2)
    );

    // word store
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    bfth_store #(
        .DEPTH (WORD_COUNT),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // word address and bit mask of each position
    logic [31:0]   w1_full, w2_full;
    logic [AW-1:0] waddr1, waddr2;
    logic [31:0]   mask1, mask2;

    assign w1_full = {15'd0, pos1_reg} >> 5;
    assign w2_full = {15'd0, pos2_reg} >> 5;
    assign waddr1  = w1_full[AW-1:0];
    assign waddr2  = w2_full[AW-1:0];
    assign mask1   = 32'd1 << pos1_reg[4:0];
    assign mask2   = 32'd1 << pos2_reg[4:0];

    logic in_xfer;
    logic out_free;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // sequencer: next state and store access
    always_comb
    begin
        state_next = state_reg;
        hash_start = 1'b0;
        mod_start  = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = waddr1;
        mem_wdata  = mem_rdata | mask1;
        unique case (state_reg)
            bfth_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = 32'd0;
                if (clr_cnt_reg == LAST_WORD)
                    state_next = bfth_pkg::ST_IDLE;
            end
            bfth_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = bfth_pkg::ST_HASH;
            end
            bfth_pkg::ST_HASH:
            begin
                // start pulse is issued on entry through hash_go
                if (hash_done)
                begin
                    mod_start  = 1'b1;
                    state_next = bfth_pkg::ST_MOD;
                end
            end
            bfth_pkg::ST_MOD:
            begin
                if (mod1_done && mod2_done)
                    state_next = bfth_pkg::ST_RD1;
            end
            bfth_pkg::ST_RD1:
            begin
                mem_addr = waddr1;
                if (op_reg == bfth_pkg::OP_ADD)
                    state_next = bfth_pkg::ST_WR1;
                else
                    state_next = bfth_pkg::ST_RD2;
            end
            bfth_pkg::ST_WR1:
            begin
                // read-modify-write of the first word
                mem_we     = 1'b1;
                mem_addr   = waddr1;
                mem_wdata  = mem_rdata | mask1;
                state_next = bfth_pkg::ST_RD2;
            end
            bfth_pkg::ST_RD2:
            begin
                // for an add the second read follows the first write, so a shared word is seen updated
                mem_addr = waddr2;
                if (op_reg == bfth_pkg::OP_ADD)
                    state_next = bfth_pkg::ST_WR2;
                else
                    state_next = bfth_pkg::ST_CHK;
            end
            bfth_pkg::ST_WR2:
            begin
                mem_we     = 1'b1;
                mem_addr   = waddr2;
                mem_wdata  = mem_rdata | mask2;
                state_next = bfth_pkg::ST_IDLE;
            end
            bfth_pkg::ST_CHK:
            begin
                mem_addr = waddr2;
                if (out_free)
                    state_next = bfth_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bfth_pkg::ST_IDLE;
            end
        endcase
        // the captured key is valid in the cycle after the transfer
        if (state_reg == bfth_pkg::ST_HASH && hash_go_reg)
            hash_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bfth_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            active_bits_reg <= 17'd65536;
            out_valid_reg   <= 1'b0;
            hash_go_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hash_go_reg <= in_xfer;
            if (state_reg == bfth_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cfg_wr_en)
                active_bits_reg <= cfg_wr_data;
            if (state_reg == bfth_pkg::ST_CHK && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        if (state_reg == bfth_pkg::ST_MOD && mod1_done && mod2_done)
        begin
            pos1_reg <= rem1;
            pos2_reg <= rem2;
        end
        if (state_reg == bfth_pkg::ST_RD2)
            bit1_reg <= |(mem_rdata & mask1);
        if (state_reg == bfth_pkg::ST_CHK && out_free)
            maybe_reg <= bit1_reg && (|(mem_rdata & mask2));
    end

    assign in_stall      = (state_reg != bfth_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign maybe_present = maybe_reg;

endmodule

// ----- src/bfth_checker.sv -----
`timescale 1ns / 1ps
// bfth_checker: port-level checks of the bloom filter, bound to the top level
// no package dependency

module bfth_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic maybe_present
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(maybe_present))
        else $error("stalled result changed");

    // an input transfer closes the input side behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input reopened too early");

    // a new result only appears while an item is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without item in flight");

endmodule

bind bloom_filter_two_hash bfth_checker u_bfth_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .maybe_present (maybe_present)
);

// ----- test/tb_bloom_filter_two_hash.sv -----
`timescale 1ns / 1ps
// testbench for bloom_filter_two_hash: queued driver, clocked monitor, own filter model
// depends on bfth_pkg and bloom_filter_two_hash

module tb_bloom_filter_two_hash;

    localparam int FILTER_BITS = 65536;
    localparam int WORDS = FILTER_BITS / 32;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [31:0] MUL = 32'h5bd1e995;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key;
    } filter_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = bfth_pkg::OP_ADD;
    logic [31:0] key = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        maybe_present;
    logic        cfg_wr_en = 1'b0;
    logic [16:0] cfg_wr_data = '0;

    bloom_filter_two_hash #(.FILTER_BITS(FILTER_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .key(key),
        .out_valid(out_valid), .out_stall(out_stall), .maybe_present(maybe_present),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #4 clk = ~clk;

    // model state
    logic [31:0] shadow_words [WORDS];
    logic [16:0] shadow_bits;

    filter_req_t pending_reqs[$];
    logic        expected_present[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    int          idle_cycles = 0;

    function automatic logic [31:0] murmur_hash(logic [31:0] k);
        logic [31:0] x;
        logic [31:0] h;
        x = k * MUL;
        x = x ^ (x >> 24);
        x = x * MUL;
        h = x ^ (x >> 13);
        h = h * MUL;
        h = h ^ (h >> 15);
        return h;
    endfunction

    function automatic logic [31:0] shift_add_hash(logic [31:0] k);
        logic [31:0] x;
        x = k;
        x = x + (x << 10);
        x = x ^ (x >> 6);
        x = x + (x << 3);
        x = x ^ (x >> 11);
        x = x + (x << 15);
        return x;
    endfunction

    // apply one accepted transfer to the model, queue the answer for queries
    task automatic predict_lookup(filter_req_t r);
        logic [31:0] n;
        logic [31:0] p1;
        logic [31:0] p2;
        n = {15'd0, shadow_bits};
        if (n == 32'd0) n = 32'd1;
        if (n > 32'(FILTER_BITS)) n = 32'(FILTER_BITS);
        p1 = murmur_hash(r.key) % n;
        p2 = shift_add_hash(r.key) % n;
        if (r.opcode == bfth_pkg::OP_ADD) begin
            shadow_words[p1 / 32][p1 % 32] = 1'b1;
            shadow_words[p2 / 32][p2 % 32] = 1'b1;
        end
        else begin
            expected_present.push_back(shadow_words[p1 / 32][p1 % 32] &
                                       shadow_words[p2 / 32][p2 % 32]);
        end
    endtask

    // driver: present the head of the queue, hold it while stalled
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_lookup(filter_req_t'{opcode, key});
                void'(pending_reqs.pop_front());
            end
            if (in_valid && in_stall) begin
                // payload held
            end
            else if (pending_reqs.size() != 0
                     && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                opcode   <= pending_reqs[0].opcode;
                key      <= pending_reqs[0].key;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result transfer against the oldest answer
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_present.size() == 0) begin
                    $error("maybe_present: unexpected result %0b", maybe_present);
                    errors++;
                end
                else begin
                    logic want;
                    want = expected_present.pop_front();
                    if (want !== maybe_present) begin
                        $error("maybe_present: expected %0b actual %0b", want, maybe_present);
                        errors++;
                    end
                end
            end
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[bloom_filter_two_hash] ERROR");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_present.size() != 0 || in_valid)
            @(posedge clk);
        // an add can still be in flight after the last query result
        repeat (100) @(posedge clk);
    endtask

    task automatic write_bits(logic [16:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_bits = v;
    endtask

    // add-then-query pairs so queries hit set bits, mixed with single adds and random probes
    task automatic queue_random(int count, int key_span);
        filter_req_t r;
        logic [31:0] k;
        for (int i = 0; i < count; i++) begin
            k = (key_span == 0) ? $urandom() : $urandom_range(key_span);
            case ($urandom_range(3))
                0: begin
                    pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_ADD, k});
                    pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, k});
                    i++;
                end
                1: pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_ADD, k});
                default: pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, k});
            endcase
        end
    endtask

    initial
    begin
        for (int i = 0; i < WORDS; i++) shadow_words[i] = '0;
        shadow_bits = 17'd65536;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme keys at reset bit count
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'h0});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_ADD, 32'h0});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'h0});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_ADD, 32'hffffffff});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'hffffffff});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'h80000000});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'h55555555});
        drain();
        // zero bit count acts as one bit
        write_bits(17'd0);
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'h12345678});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'haaaaaaaa});
        drain();
        // bit count of one, then past the store is saturated
        write_bits(17'd1);
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'hdeadbeef});
        drain();
        write_bits(17'h1ffff);
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'hffffffff});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_ADD, 32'hcafef00d});
        pending_reqs.push_back(filter_req_t'{bfth_pkg::OP_QUERY, 32'hcafef00d});
        drain();

        // phase 1: sender idles lightly, receiver heavily, small filter
        send_idle_pct = 15;
        recv_idle_pct = 86;
        write_bits(17'd37);
        queue_random(500, 0);
        drain();

        // phase 2: swapped, with a long receiver hold-off
        send_idle_pct = 86;
        recv_idle_pct = 15;
        write_bits(17'd4096);
        send_idle_pct = 0;
        hold_off = 1'b1;
        queue_random(40, 0);
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
        send_idle_pct = 86;
        queue_random(460, 0);
        drain();

        // phase 3: no idling, full range and a tiny one
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_bits(17'd65536);
        queue_random(500, 0);
        drain();
        write_bits(17'd3);
        queue_random(450, 255);
        drain();

        if (errors == 0 && expected_present.size() == 0)
            $display("[bloom_filter_two_hash] OK");
        else
            $display("[bloom_filter_two_hash] ERROR");
        $finish;
    end

endmodule
